// ----- design/pfab_pkg.sv -----
package pfab_pkg;

  // Source formats
  localparam logic [2:0] SRC_RGB565   = 3'd0;
  localparam logic [2:0] SRC_RGB888   = 3'd1;
  localparam logic [2:0] SRC_ARGB8565 = 3'd2;
  localparam logic [2:0] SRC_ARGB8888 = 3'd3;
  localparam logic [2:0] SRC_PALETTE  = 3'd4;
  localparam logic [2:0] SRC_MASK     = 3'd5;

  // Destination formats
  localparam logic [1:0] DST_RGB565   = 2'd0;
  localparam logic [1:0] DST_RGB888   = 2'd1;
  localparam logic [1:0] DST_ARGB8888 = 2'd2;

  // Blend modes
  localparam logic [1:0] BLEND_COVER = 2'd0;
  localparam logic [1:0] BLEND_FADE  = 2'd1;
  localparam logic [1:0] BLEND_FILTER = 2'd2;
  localparam logic [1:0] BLEND_OVER  = 2'd3;

  // Register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_FORMAT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPACITY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_SEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_COLOR  = 3'd4;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [15:0] ROUND_BIAS  = 16'd127;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } argb_t;

  typedef struct packed {
    logic [2:0]  src_format;
    logic [1:0]  dst_format;
    logic [7:0]  opacity;
    logic [1:0]  blend_sel;
    logic [31:0] mix_color;
  } cfg_t;

  // After unpack
  typedef struct packed {
    argb_t       src;
    argb_t       dst;
    logic [15:0] mask_prod;
  } dec_t;

  // After alpha resolve
  typedef struct packed {
    argb_t src;
    argb_t dst;
  } alp_t;

  // After weight
  typedef struct packed {
    argb_t      src;
    argb_t      dst;
    logic [7:0] w;
    logic [7:0] salpha;
    logic       bypass;
    argb_t      byp;
  } wgt_t;

  // After mix products
  typedef struct packed {
    logic [15:0] t_a;
    logic [15:0] t_r;
    logic [15:0] t_g;
    logic [15:0] t_b;
    logic        bypass;
    argb_t       byp;
  } mix_t;

  // floor(p / 255), exact for p up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
    return s[15:8];
  endfunction

  // (t * 257) >> 16, low eight bits
  function automatic logic [7:0] round255(input logic [15:0] t);
    logic [23:0] s;
    s = {t, 8'd0} + {8'd0, t};
    return s[23:16];
  endfunction

endpackage

// ----- design/pfab_unpack.sv -----
module pfab_unpack
  import pfab_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  cfg_t        cfg,
  input  logic [31:0] src_pixel,
  input  logic [31:0] dst_pixel,
  output dec_t        dec
);

  argb_t       src_x;
  argb_t       dst_x;
  logic [15:0] mprod;

  always_comb begin
    src_x = '{a: src_pixel[31:24], r: src_pixel[23:16], g: src_pixel[15:8], b: src_pixel[7:0]};
    case (cfg.src_format)
      SRC_RGB565: begin
        src_x = '{a: ALPHA_OPAQUE, r: {src_pixel[15:11], 3'd0},
                  g: {src_pixel[10:5], 2'd0}, b: {src_pixel[4:0], 3'd0}};
      end
      SRC_ARGB8565: begin
        src_x = '{a: src_pixel[23:16], r: {src_pixel[15:11], 3'd0},
                  g: {src_pixel[10:5], 2'd0}, b: {src_pixel[4:0], 3'd0}};
      end
      SRC_RGB888, SRC_PALETTE: begin
        src_x.a = ALPHA_OPAQUE;
      end
      SRC_MASK: begin
        // alpha gets resolved one stage later from the mask product
        src_x = '{a: ALPHA_OPAQUE, r: cfg.mix_color[23:16],
                  g: cfg.mix_color[15:8], b: cfg.mix_color[7:0]};
      end
      default: ;
    endcase
  end

  always_comb begin
    dst_x = '{a: dst_pixel[31:24], r: dst_pixel[23:16], g: dst_pixel[15:8], b: dst_pixel[7:0]};
    case (cfg.dst_format)
      DST_RGB565: begin
        dst_x = '{a: ALPHA_OPAQUE, r: {dst_pixel[15:11], 3'd0},
                  g: {dst_pixel[10:5], 2'd0}, b: {dst_pixel[4:0], 3'd0}};
      end
      DST_RGB888: begin
        dst_x.a = ALPHA_OPAQUE;
      end
      default: ;
    endcase
  end

  assign mprod = 16'(src_pixel[7:0]) * 16'(cfg.mix_color[31:24]);

  always_ff @(posedge clk) begin
    if (en) begin
      dec <= '{src: src_x, dst: dst_x, mask_prod: mprod};
    end
  end

endmodule

// ----- design/pfab_weight.sv -----
module pfab_weight
  import pfab_pkg::*;
(
  input  logic clk,
  input  logic en_alpha,
  input  logic en_weight,
  input  cfg_t cfg,
  input  dec_t dec,
  output wgt_t wgt
);

  alp_t        alp;
  argb_t       src_a;
  logic [15:0] wprod;
  logic [7:0]  wdiv;
  wgt_t        wgt_next;

  always_comb begin
    src_a = dec.src;
    if (cfg.src_format == SRC_MASK) begin
      src_a.a = div255(dec.mask_prod);
    end
  end

  always_ff @(posedge clk) begin
    if (en_alpha) begin
      alp <= '{src: src_a, dst: dec.dst};
    end
  end

  assign wprod = 16'(alp.src.a) * 16'(cfg.opacity);
  assign wdiv  = div255(wprod);

  always_comb begin
    wgt_next.src    = alp.src;
    wgt_next.dst    = alp.dst;
    wgt_next.w      = wdiv;
    wgt_next.salpha = wdiv;
    wgt_next.bypass = 1'b0;
    wgt_next.byp    = alp.src;
    case (cfg.blend_sel)
      BLEND_COVER: begin
        wgt_next.bypass = 1'b1;
      end
      BLEND_FADE: begin
        wgt_next.w      = cfg.opacity;
        wgt_next.salpha = alp.src.a;
      end
      BLEND_FILTER: begin
        // black key: keep the destination
        if (alp.src.r == 8'd0 && alp.src.g == 8'd0 && alp.src.b == 8'd0) begin
          wgt_next.bypass = 1'b1;
          wgt_next.byp    = alp.dst;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_weight) begin
      wgt <= wgt_next;
    end
  end

endmodule

// ----- design/pfab_mix.sv -----
module pfab_mix
  import pfab_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  wgt_t wgt,
  output mix_t mix
);

  logic [7:0] inv_w;

  assign inv_w = ~wgt.w;

  function automatic logic [15:0] blend_sum(input logic [7:0] iw, input logic [7:0] d,
                                            input logic [7:0] w, input logic [7:0] s);
    return 16'(iw) * 16'(d) + 16'(w) * 16'(s) + ROUND_BIAS;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      mix.t_a    <= blend_sum(inv_w, wgt.dst.a, wgt.w, wgt.salpha);
      mix.t_r    <= blend_sum(inv_w, wgt.dst.r, wgt.w, wgt.src.r);
      mix.t_g    <= blend_sum(inv_w, wgt.dst.g, wgt.w, wgt.src.g);
      mix.t_b    <= blend_sum(inv_w, wgt.dst.b, wgt.w, wgt.src.b);
      mix.bypass <= wgt.bypass;
      mix.byp    <= wgt.byp;
    end
  end

endmodule

// ----- design/pfab_pack.sv -----
module pfab_pack
  import pfab_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  cfg_t        cfg,
  input  mix_t        mix,
  output logic [31:0] out_pixel
);

  argb_t       c;
  logic [31:0] packed_px;

  always_comb begin
    if (mix.bypass) begin
      c = mix.byp;
    end else begin
      c = '{a: round255(mix.t_a), r: round255(mix.t_r),
            g: round255(mix.t_g), b: round255(mix.t_b)};
    end
  end

  always_comb begin
    case (cfg.dst_format)
      DST_RGB565: packed_px = {16'd0, c.r[7:3], c.g[7:2], c.b[7:3]};
      DST_RGB888: packed_px = {8'd0, c.r, c.g, c.b};
      default:    packed_px = {c.a, c.r, c.g, c.b};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pixel <= packed_px;
    end
  end

endmodule

// ----- design/pixel_format_alpha_blend_unit.sv -----
// Channel   | handshake                 | payload
// ----------+---------------------------+--------------------------------
// pixel in  | pix_valid / pix_stall     | src_pixel[31:0], dst_pixel[31:0]
// result    | res_valid / res_stall     | out_pixel[31:0]
// config    | cfg_we                    | cfg_index[2:0], cfg_data[31:0]
//
// One pixel per clock while res_stall is low; a beat passes five register stages (unpack,
// alpha resolve, weight, mix products, round and pack) on its way to out_pixel.
// Reset (rst, synchronous) empties the pipe and loads the register defaults.
// Each stage holds only while it is full and the stage after it holds, so
// bubbles close up under res_stall; pix_stall rises only when all five stages are full.
module pixel_format_alpha_blend_unit
  import pfab_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  logic [31:0]          src_pixel,
  input  logic [31:0]          dst_pixel,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [31:0]          out_pixel
);

  cfg_t       cfg;
  logic [3:0] vld;   // valid bits of the four inner stages
  logic [4:0] en;    // advance enable per stage, last one is the output register
  dec_t       dec;
  wgt_t       wgt;
  mix_t       mix;

  // Configuration registers; writes past the last index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_format <= SRC_ARGB8888;
      cfg.dst_format <= DST_ARGB8888;
      cfg.opacity    <= 8'hff;
      cfg.blend_sel  <= BLEND_OVER;
      cfg.mix_color  <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_FORMAT: cfg.src_format <= cfg_data[2:0];
        CFG_DST_FORMAT: cfg.dst_format <= cfg_data[1:0];
        CFG_OPACITY:    cfg.opacity    <= cfg_data[7:0];
        CFG_BLEND_SEL:  cfg.blend_sel  <= cfg_data[1:0];
        CFG_MIX_COLOR:  cfg.mix_color  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or the next one advances.
  always_comb begin
    en[4] = !res_valid || !res_stall;
    for (int k = 3; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign pix_stall = !en[0];

  // Valid bits travel with the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (en[0]) vld[0] <= pix_valid;
      for (int k = 1; k < 4; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
      if (en[4]) res_valid <= vld[3];
    end
  end

  pfab_unpack u_unpack (
    .clk       (clk),
    .en        (en[0]),
    .cfg       (cfg),
    .src_pixel (src_pixel),
    .dst_pixel (dst_pixel),
    .dec       (dec)
  );

  pfab_weight u_weight (
    .clk       (clk),
    .en_alpha  (en[1]),
    .en_weight (en[2]),
    .cfg       (cfg),
    .dec       (dec),
    .wgt       (wgt)
  );

  pfab_mix u_mix (
    .clk (clk),
    .en  (en[3]),
    .wgt (wgt),
    .mix (mix)
  );

  pfab_pack u_pack (
    .clk       (clk),
    .en        (en[4]),
    .cfg       (cfg),
    .mix       (mix),
    .out_pixel (out_pixel)
  );

  // Input backpressure only when the whole pipe is full and the output holds.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (&vld && res_valid && res_stall))
    else $error("pix_stall with a bubble in the pipe");

  // An accepted beat lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !pix_stall) |=> vld[0])
    else $error("accepted beat lost at entry");

  // A beat in the last inner stage that advances reaches the output.
  a_reach_out: assert property (@(posedge clk) disable iff (rst)
    (vld[3] && en[4]) |=> res_valid)
    else $error("beat lost before output");

  // A held stage keeps its beat.
  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (vld[3] && !en[3]) |=> vld[3])
    else $error("held beat dropped");

endmodule

// ----- tb/tb_pixel_format_alpha_blend_unit.sv -----
module tb_pixel_format_alpha_blend_unit;
  import pfab_pkg::*;

  // Codes the package leaves unnamed: the decode falls back to argb8888 for these.
  localparam logic [2:0] SRC_SPARE_LO = 3'd6;
  localparam logic [2:0] SRC_SPARE_HI = 3'd7;
  localparam logic [1:0] DST_SPARE    = 2'd3;
  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  // Receiver stall patterns
  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;
  localparam int STALL_LONG  = 3;

  localparam int SETTLE_CYCLES = 10;      // five stages plus margin
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_PIXELS  = 32;

  // Expected output pixels, one entry per accepted input beat.
  class blend_scoreboard;
    typedef struct {
      logic [31:0] src;
      logic [31:0] dst;
      logic [31:0] pix;
    } pending_pix_t;

    logic [2:0]  src_fmt;
    logic [1:0]  dst_fmt;
    logic [7:0]  opac;
    logic [1:0]  mode;
    logic [31:0] mix;
    pending_pix_t waiting[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      src_fmt = SRC_ARGB8888;
      dst_fmt = DST_ARGB8888;
      opac    = 8'hff;
      mode    = BLEND_OVER;
      mix     = 32'h0;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_SRC_FORMAT: src_fmt = data[2:0];
        CFG_DST_FORMAT: dst_fmt = data[1:0];
        CFG_OPACITY:    opac    = data[7:0];
        CFG_BLEND_SEL:  mode    = data[1:0];
        CFG_MIX_COLOR:  mix     = data;
        default: ;
      endcase
    endfunction

    function argb_t split565(logic [31:0] p);
      argb_t c;
      c.a = ALPHA_OPAQUE;
      c.r = {p[15:11], 3'b000};
      c.g = {p[10:5], 2'b00};
      c.b = {p[4:0], 3'b000};
      return c;
    endfunction

    function argb_t widen_src(logic [31:0] p);
      argb_t c;
      int unsigned ma;
      case (src_fmt)
        SRC_RGB565: c = split565(p);
        SRC_RGB888, SRC_PALETTE: begin
          c = argb_t'(p);
          c.a = ALPHA_OPAQUE;
        end
        SRC_ARGB8565: begin
          c = split565(p);
          c.a = p[23:16];
        end
        SRC_MASK: begin
          c = argb_t'(mix);
          ma = (32'(p[7:0]) * 32'(c.a)) / 255;
          c.a = ma[7:0];
        end
        default: c = argb_t'(p);
      endcase
      return c;
    endfunction

    function argb_t widen_dst(logic [31:0] p);
      argb_t c;
      case (dst_fmt)
        DST_RGB565: c = split565(p);
        DST_RGB888: begin
          c = argb_t'(p);
          c.a = ALPHA_OPAQUE;
        end
        default: c = argb_t'(p);
      endcase
      return c;
    endfunction

    function logic [31:0] pack(argb_t c);
      case (dst_fmt)
        DST_RGB565: return {16'd0, c.r[7:3], c.g[7:2], c.b[7:3]};
        DST_RGB888: return {8'd0, c.r, c.g, c.b};
        default:    return c;
      endcase
    endfunction

    // Rounded divide by 255 of the weighted sum, as (t * 257) >> 16.
    function logic [7:0] blend_chan(logic [7:0] d, logic [7:0] s, logic [7:0] a);
      int unsigned t;
      int unsigned q;
      t = (32'd255 - 32'(a)) * 32'(d) + 32'(a) * 32'(s) + 32'(ROUND_BIAS);
      q = (t * 32'd257) >> 16;
      return q[7:0];
    endfunction

    function argb_t blend_pix(argb_t d, argb_t s, logic [7:0] a, logic [7:0] sa);
      argb_t o;
      o.a = blend_chan(d.a, sa, a);
      o.r = blend_chan(d.r, s.r, a);
      o.g = blend_chan(d.g, s.g, a);
      o.b = blend_chan(d.b, s.b, a);
      return o;
    endfunction

    function logic [31:0] predict(logic [31:0] src_raw, logic [31:0] dst_raw);
      argb_t s;
      argb_t d;
      argb_t r;
      int unsigned w;
      s = widen_src(src_raw);
      d = widen_dst(dst_raw);
      w = (32'(s.a) * 32'(opac)) / 255;
      case (mode)
        BLEND_COVER: r = s;
        BLEND_FADE:  r = blend_pix(d, s, opac, s.a);
        BLEND_FILTER: begin
          // black key: keep the destination as it was
          if (s.r == 8'd0 && s.g == 8'd0 && s.b == 8'd0) r = d;
          else r = blend_pix(d, s, w[7:0], w[7:0]);
        end
        default: r = blend_pix(d, s, w[7:0], w[7:0]);
      endcase
      return pack(r);
    endfunction

    function void note_pixel(logic [31:0] src_raw, logic [31:0] dst_raw);
      pending_pix_t e;
      e.src = src_raw;
      e.dst = dst_raw;
      e.pix = predict(src_raw, dst_raw);
      waiting.push_back(e);
    endfunction

    function void check_pixel(logic [31:0] actual);
      pending_pix_t e;
      if (waiting.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: out_pixel %08h with no pixel outstanding", actual);
        return;
      end
      e = waiting.pop_front();
      checked++;
      if (actual !== e.pix) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: src %08h dst %08h fmt %0d/%0d op %0d sel %0d mix %08h: exp %08h got %08h",
                   e.src, e.dst, src_fmt, dst_fmt, opac, mode, mix, e.pix, actual);
      end
    endfunction

    function int unsigned pending();
      return waiting.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;
  logic                 pix_valid = 1'b0;
  logic                 pix_stall;
  logic [31:0]          src_pixel = '0;
  logic [31:0]          dst_pixel = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [31:0]          out_pixel;

  blend_scoreboard sb = new();

  int unsigned cycles       = 0;
  int unsigned pixels_sent  = 0;
  int unsigned settings_run = 0;
  int unsigned burst_left   = 0;
  int          stall_mode   = STALL_NONE;
  int unsigned stall_left   = 0;

  pixel_format_alpha_blend_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .src_pixel (src_pixel),
    .dst_pixel (dst_pixel),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_pixel (out_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Guard against a hung pipe.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycles, sb.pending());
      $display("pixel_format_alpha_blend_unit test failed");
      $finish;
    end
  end

  // Result side: check every beat, then pick the next stall level. The pattern
  // switches between open, light, heavy and long-hold stretches on its own clock.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_pixel(out_pixel);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_LONG);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  res_stall <= 1'b0;
      STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
      default:     res_stall <= stall_left[3];  // follows bit 3 of the countdown: alternate hold and release
    endcase
  end

  // Drive one pixel beat and hold it until accepted. Bursts of random length
  // end in a random gap; a zero gap keeps valid high into the next beat.
  task automatic send_pixel(input logic [31:0] s, input logic [31:0] d);
    int unsigned gap;
    pix_valid <= 1'b1;
    src_pixel <= s;
    dst_pixel <= d;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    sb.note_pixel(s, d);
    pixels_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        pix_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Drain the pipe, then load all five registers. Unused high bits of cfg_data
  // carry noise, and the spare index gets a write that must be ignored.
  task automatic apply_cfg(input logic [2:0] sf, input logic [1:0] df, input logic [7:0] op,
                           input logic [1:0] bs, input logic [31:0] mc);
    pix_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_SRC_FORMAT, ($urandom() & ~32'h7) | 32'(sf));
    write_reg(CFG_DST_FORMAT, ($urandom() & ~32'h3) | 32'(df));
    write_reg(CFG_OPACITY, ($urandom() & ~32'hff) | 32'(op));
    write_reg(CFG_BLEND_SEL, ($urandom() & ~32'h3) | 32'(bs));
    write_reg(CFG_MIX_COLOR, mc);
    write_reg(CFG_IDX_SPARE, $urandom());
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Random source word shaped for the current setting: black keys in filter
  // mode, and alpha pinned to its extremes some of the time.
  function automatic logic [31:0] shape_src(input logic [2:0] sf, input logic [1:0] bs);
    logic [31:0] p;
    logic [7:0]  ext;
    p = $urandom();
    if (bs == BLEND_FILTER && $urandom_range(0, 2) == 0)
      p = ($urandom_range(0, 1) == 0) ? (p & 32'hff000000) : (p & 32'hffff0000);
    if ($urandom_range(0, 3) == 0) begin
      ext = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
      case (sf)
        SRC_ARGB8565: p[23:16] = ext;
        SRC_MASK:     p[7:0]   = ext;
        default:      p[31:24] = ext;
      endcase
    end
    return p;
  endfunction

  initial begin
    logic [2:0]  sf;
    logic [1:0]  df;
    logic [7:0]  op;
    logic [1:0]  bs;
    logic [31:0] mc;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: argb8888 over argb8888, full opacity, source over.
    send_pixel(32'h00000000, 32'h00000000);
    send_pixel(32'hffffffff, 32'hffffffff);
    send_pixel(32'h00ffffff, 32'h12345678);
    send_pixel(32'hff000000, 32'hffffffff);

    // Cover, 565 both sides; junk above bit 15 must vanish.
    apply_cfg(SRC_RGB565, DST_RGB565, 8'h00, BLEND_COVER, 32'h00000000);
    send_pixel(32'hffffffff, 32'hffff0000);
    send_pixel(32'hffff0000, 32'h0000ffff);

    // Opacity blend from 8565 into 888, mid weight.
    apply_cfg(SRC_ARGB8565, DST_RGB888, 8'h80, BLEND_FADE, 32'hffffffff);
    send_pixel(32'h00ff07e0, 32'hff00ff00);
    send_pixel(32'hff00f81f, 32'h00ffffff);

    // Filter black on palette triplets: a black key and a coloured source.
    apply_cfg(SRC_PALETTE, DST_ARGB8888, 8'hff, BLEND_FILTER, 32'h00000000);
    send_pixel(32'hff000000, 32'h89abcdef);
    send_pixel(32'h00000001, 32'h89abcdef);

    // Alpha mask with full and empty mask over 565.
    apply_cfg(SRC_MASK, DST_RGB565, 8'hc8, BLEND_OVER, 32'hffffffff);
    send_pixel(32'hffffffff, 32'h0000ffff);
    send_pixel(32'hffffff00, 32'h00001234);

    // Undefined format codes fall back to argb8888.
    apply_cfg(SRC_SPARE_LO, DST_SPARE, 8'hff, BLEND_OVER, 32'h00000000);
    send_pixel(32'h80ff8000, 32'h7f00ff7f);
    send_pixel(32'h00000000, 32'hffffffff);
    apply_cfg(SRC_SPARE_HI, DST_SPARE, 8'h01, BLEND_FILTER, 32'hffffffff);
    send_pixel(32'hff000000, 32'h11223344);
    send_pixel(32'hffffffff, 32'h00000000);

    // 888 filter with a black key hidden under junk alpha bits.
    apply_cfg(SRC_RGB888, DST_RGB888, 8'h01, BLEND_FILTER, 32'h00000000);
    send_pixel(32'h5a000000, 32'hffa5c3e1);
    send_pixel(32'h5a000100, 32'hffa5c3e1);

    // Random settings, random pixels.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      sf = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      df = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0:       op = 8'h00;
        1:       op = 8'hff;
        default: op = 8'($urandom());
      endcase
      bs = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0:       mc = 32'hffffffff;
        1:       mc = 32'h00000000;
        default: mc = $urandom();
      endcase
      apply_cfg(sf, df, op, bs, mc);
      repeat (PHASE_PIXELS) send_pixel(shape_src(sf, bs), $urandom());
    end

    pix_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d pixels over %0d register settings, %0d results checked",
             pixels_sent, settings_run, sb.checked);
    $display("all six source formats, undefined codes and all four blend modes exercised");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("pixel_format_alpha_blend_unit test passed");
    end else begin
      $display("%0d mismatches, %0d pixels outstanding", sb.errors, sb.pending());
      $display("pixel_format_alpha_blend_unit test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/pfab_pkg.sv
design/pfab_unpack.sv
design/pfab_weight.sv
design/pfab_mix.sv
design/pfab_pack.sv
design/pixel_format_alpha_blend_unit.sv
tb/tb_pixel_format_alpha_blend_unit.sv
